[hw/rtl/ddo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, widths and constants of the differential drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int CORDIC_STEPS           = 24;
  localparam int POSITION_FRACTION_BITS = 32;

  localparam int CW        = 34;  // CORDIC datapath, Q30 plus headroom
  localparam int STEP_W    = $clog2(CORDIC_STEPS + 1);
  localparam int PROD_W    = 96;  // 64 x 32 product
  localparam int ACC_W     = 48;
  localparam int DT_W      = 48;
  localparam int XD_SHIFT  = 70 - POSITION_FRACTION_BITS;
  localparam int XD_W      = PROD_W - XD_SHIFT;
  localparam int POS_SHIFT = POSITION_FRACTION_BITS - 16;
  localparam int RAD_SHIFT = 16;
  localparam int SHIFT_MAX = (POS_SHIFT > RAD_SHIFT) ? POS_SHIFT : RAD_SHIFT;
  localparam int DVS_W     = DT_W + SHIFT_MAX;
  localparam int QUOT_W    = 31;
  localparam int REM_W     = ((PROD_W - QUOT_W) > (DVS_W + 1)) ?
                             (PROD_W - QUOT_W) : (DVS_W + 1);

  localparam logic [31:0]          INV_PI_Q32 = 32'd1367130551;
  localparam logic [31:0]          MICRO      = 32'd1000000;
  localparam logic signed [CW-1:0] CORDIC_X0  = 34'sd652032874;

  typedef enum logic [1:0] {
    REG_START_LEFT,
    REG_START_RIGHT,
    REG_METERS_PER_COUNT,
    REG_INV_WHEEL_BASE
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_ADD,
    S_POST,
    S_CSTART,
    S_CORDIC,
    S_DSTART,
    S_DIV,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_TOTAL,
    OP_DEL,
    OP_RAD,
    OP_BAM,
    OP_XD,
    OP_YD,
    OP_VX,
    OP_VY,
    OP_VR
  } op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cor_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_stat_t;

  // arctangent of 2^-k as binary angle, 2^31 = pi
  function automatic logic [31:0] atan_entry(input logic [4:0] k);
    logic [31:0] v;
    unique case (k)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      5'd31: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/differential_drive_odometry.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Wheel odometry, midpoint rule: wheel counts and timestamp in, pose and
// velocities out.
// ----------------------------------------------------------------------------
// One item at a time. Velocities are computed only after the first item and
// for a forward time step; an item also waits for the output register to
// drain. An item's time is set by one shared 32x32 multiplier (MUL_LO, MUL_HI,
// MUL_ADD and POST states per 64x32 product, nine products at most), the
// 24-step CORDIC with its start state and a divider that yields one quotient
// bit per cycle, with its start and overflow check. A finished result waits
// in the output register while the next item is taken. Configuration writes
// load the start counts into the previous counts as well.
module differential_drive_odometry (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  ddo_pkg::cfg_reg_t   cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  count_left,
  input  logic signed [31:0]  count_right,
  input  logic [47:0]         time_us,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  pos_x,
  output logic signed [31:0]  pos_y,
  output logic signed [31:0]  heading,
  output logic signed [31:0]  vel_x,
  output logic signed [31:0]  vel_y,
  output logic signed [31:0]  vel_heading,
  output logic                velocity_valid
);
  import ddo_pkg::*;

  localparam logic [ACC_W-1:0] D_LIM = {{(ACC_W-1){1'b1}}, 1'b0};
  localparam int               CMP_W = XD_W + ACC_W;

  function automatic logic signed [ACC_W-1:0] add_sat(
    input logic signed [ACC_W-1:0] acc,
    input logic [XD_W-1:0]         m,
    input logic                    neg
  );
    logic [ACC_W-1:0]         dm;
    logic signed [ACC_W+1:0]  d;
    logic signed [ACC_W+1:0]  r;
    logic signed [ACC_W-1:0]  res;
    dm = (CMP_W'(m) > CMP_W'(D_LIM)) ? D_LIM : ACC_W'(m);
    d  = $signed({2'b00, dm});
    if (neg) d = -d;
    r = $signed({{2{acc[ACC_W-1]}}, acc}) + d;
    if (r[ACC_W+1] == r[ACC_W] && r[ACC_W] == r[ACC_W-1]) res = r[ACC_W-1:0];
    else if (r[ACC_W+1]) res = {1'b1, {(ACC_W-1){1'b0}}};
    else res = {1'b0, {(ACC_W-1){1'b1}}};
    return res;
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [ACC_W-1:0] v);
    logic [31:0] res;
    if (&v[ACC_W-1:31] || ~|v[ACC_W-1:31]) res = v[31:0];
    else if (v[ACC_W-1]) res = 32'h8000_0000;
    else res = 32'h7FFF_FFFF;
    return res;
  endfunction

  function automatic logic [31:0] vel_fin(
    input logic              ovf,
    input logic [QUOT_W-1:0] q,
    input logic              neg
  );
    logic [31:0] res;
    if (ovf) res = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else res = neg ? 32'd0 - {1'b0, q} : {1'b0, q};
    return res;
  endfunction

  state_t state, state_next;
  op_t    op;

  logic [31:0] start_left, start_right, mpc, iwb;
  logic [31:0] prev_left, prev_right;
  logic [47:0] last_time;
  logic        time_seen;
  logic signed [ACC_W-1:0] acc_x, acc_y;
  logic [31:0] acc_heading;

  logic [32:0]       sum_r, del_r;
  logic [DT_W-1:0]   dt_r;
  logic              valid_r;
  logic [62:0]       total_mag;
  logic              total_neg;
  logic [63:0]       m1, rad;
  logic              rneg;
  logic [31:0]       bam, half;
  logic [XD_W-1:0]   xd_mag, yd_mag;
  logic              xd_neg, yd_neg;
  logic [31:0]       vx, vy, vr;

  logic [63:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       pm;
  logic [PROD_W-1:0] prod;

  logic [31:0] dl, dr;
  logic [32:0] sum_in, del_in, sum_mag, del_mag;
  logic [31:0] cmag, smag;
  logic [DVS_W-1:0] dvs_sel;

  cor_stat_t            cor_stat;
  div_stat_t            div_stat;
  logic signed [CW-1:0] cor_cos, cor_sin;
  logic [QUOT_W-1:0]    quot;
  logic [31:0]          mid;
  logic [31:0]          vel_new;

  assign dl      = count_left - prev_left;
  assign dr      = count_right - prev_right;
  assign sum_in  = {dl[31], dl} + {dr[31], dr};
  assign del_in  = {dl[31], dl} - {dr[31], dr};
  assign sum_mag = sum_r[32] ? 33'd0 - sum_r : sum_r;
  assign del_mag = del_r[32] ? 33'd0 - del_r : del_r;
  assign cmag    = cor_cos[CW-1] ? 32'(-cor_cos) : 32'(cor_cos);
  assign smag    = cor_sin[CW-1] ? 32'(-cor_sin) : 32'(cor_sin);
  assign mid     = acc_heading + half;
  assign dvs_sel = (op == OP_VR) ? DVS_W'(dt_r) << RAD_SHIFT : DVS_W'(dt_r) << POS_SHIFT;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    unique case (op)
      OP_VX:   vel_new = vel_fin(div_stat.ovf, quot, xd_neg);
      OP_VY:   vel_new = vel_fin(div_stat.ovf, quot, yd_neg);
      default: vel_new = vel_fin(div_stat.ovf, quot, rneg);
    endcase
  end

  always_comb begin
    unique case (op)
      OP_TOTAL: begin mul_a = 64'(sum_mag);           mul_b = mpc;        end
      OP_DEL:   begin mul_a = 64'(del_mag);           mul_b = mpc;        end
      OP_RAD:   begin mul_a = m1;                     mul_b = iwb;        end
      OP_BAM:   begin mul_a = rad;                    mul_b = INV_PI_Q32; end
      OP_XD:    begin mul_a = {1'b0, total_mag};      mul_b = cmag;       end
      OP_YD:    begin mul_a = {1'b0, total_mag};      mul_b = smag;       end
      OP_VX:    begin mul_a = 64'(xd_mag);            mul_b = MICRO;      end
      OP_VY:    begin mul_a = 64'(yd_mag);            mul_b = MICRO;      end
      default:  begin mul_a = rad;                    mul_b = MICRO;      end
    endcase
  end

  ddo_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_CSTART),
    .angle   (mid),
    .stat    (cor_stat),
    .cos_out (cor_cos),
    .sin_out (cor_sin)
  );

  ddo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DSTART),
    .dividend (prod),
    .divisor  (dvs_sel),
    .stat     (div_stat),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_MUL_LO;
      S_MUL_LO:  state_next = S_MUL_HI;
      S_MUL_HI:  state_next = S_MUL_ADD;
      S_MUL_ADD: state_next = S_POST;
      S_POST: begin
        unique case (op)
          OP_BAM:                state_next = S_CSTART;
          OP_YD:                 state_next = valid_r ? S_MUL_LO : S_OUT;
          OP_VX, OP_VY, OP_VR:   state_next = S_DSTART;
          default:               state_next = S_MUL_LO;
        endcase
      end
      S_CSTART:  state_next = S_CORDIC;
      S_CORDIC:  if (cor_stat.done) state_next = S_MUL_LO;
      S_DSTART:  state_next = S_DIV;
      S_DIV:     if (div_stat.done) state_next = (op == OP_VR) ? S_OUT : S_MUL_LO;
      S_OUT:     if (!out_valid || out_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // configuration and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_left  <= '0;
      start_right <= '0;
      mpc         <= 32'd13703900;
      iwb         <= 32'd37617035;
      prev_left   <= '0;
      prev_right  <= '0;
      last_time   <= '0;
      time_seen   <= 1'b0;
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START_LEFT:       begin start_left <= cfg_data;  prev_left <= cfg_data;  end
          REG_START_RIGHT:      begin start_right <= cfg_data; prev_right <= cfg_data; end
          REG_METERS_PER_COUNT: mpc <= cfg_data;
          REG_INV_WHEEL_BASE:   iwb <= cfg_data;
        endcase
      end
      if (in_valid && in_ready) begin
        prev_left  <= count_left;
        prev_right <= count_right;
        last_time  <= time_us;
        time_seen  <= 1'b1;
      end
      if (state == S_POST && op == OP_XD)
        acc_x <= add_sat(acc_x, prod[PROD_W-1:XD_SHIFT], total_neg ^ cor_cos[CW-1]);
      if (state == S_POST && op == OP_YD) begin
        acc_y       <= add_sat(acc_y, prod[PROD_W-1:XD_SHIFT], total_neg ^ cor_sin[CW-1]);
        acc_heading <= acc_heading + bam;
      end
      if (state == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        sum_r   <= sum_in;
        del_r   <= del_in;
        rneg    <= del_in[32];
        dt_r    <= time_us - last_time;
        valid_r <= time_seen && (time_us > last_time);
        op      <= OP_TOTAL;
      end
      S_MUL_LO: pm <= 64'(mul_a[31:0]) * 64'(mul_b);
      S_MUL_HI: begin
        prod <= PROD_W'(pm);
        pm   <= 64'(mul_a[63:32]) * 64'(mul_b);
      end
      S_MUL_ADD: prod <= prod + {pm, 32'd0};
      S_POST: begin
        unique case (op)
          OP_TOTAL: begin
            total_mag <= prod[63:1];
            total_neg <= sum_r[32];
            op        <= OP_DEL;
          end
          OP_DEL: begin
            m1 <= prod[63:0];
            op <= OP_RAD;
          end
          OP_RAD: begin
            rad <= prod[95:32];
            op  <= OP_BAM;
          end
          OP_BAM: begin
            bam  <= rneg ? 32'd0 - prod[64:33] : prod[64:33];
            half <= rneg ? 32'd0 - prod[65:34] : prod[65:34];
          end
          OP_XD: begin
            xd_mag <= prod[PROD_W-1:XD_SHIFT];
            xd_neg <= total_neg ^ cor_cos[CW-1];
            op     <= OP_YD;
          end
          OP_YD: begin
            yd_mag <= prod[PROD_W-1:XD_SHIFT];
            yd_neg <= total_neg ^ cor_sin[CW-1];
            vx     <= '0;
            vy     <= '0;
            vr     <= '0;
            op     <= OP_VX;
          end
          default: ;
        endcase
      end
      S_CORDIC: if (cor_stat.done) op <= OP_XD;
      S_DIV: begin
        if (div_stat.done) begin
          unique case (op)
            OP_VX:   begin vx <= vel_new; op <= OP_VY; end
            OP_VY:   begin vy <= vel_new; op <= OP_VR; end
            default: vr <= vel_new;
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          pos_x          <= clamp32(acc_x >>> POS_SHIFT);
          pos_y          <= clamp32(acc_y >>> POS_SHIFT);
          heading        <= acc_heading;
          vel_x          <= vx;
          vel_y          <= vy;
          vel_heading    <= vr;
          velocity_valid <= valid_r;
        end
      end
      default: ;
    endcase
  end

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE))
    else $error("item transfer did not start the sequencer");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_DSTART) |-> !div_stat.busy)
    else $error("divider started while busy");

  a_cordic_done: assert property (@(posedge clk) disable iff (rst)
    cor_stat.done |-> (state == S_CORDIC))
    else $error("CORDIC finished outside its wait state");

  a_heading_hold: assert property (@(posedge clk) disable iff (rst)
    !(state == S_POST && op == OP_YD) |=> $stable(acc_heading))
    else $error("heading changed outside its update step");

endmodule

[hw/rtl/ddo_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, quadrant folded.
// ----------------------------------------------------------------------------
module ddo_cordic (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [31:0]                    angle,
  output ddo_pkg::cor_stat_t             stat,
  output logic signed [ddo_pkg::CW-1:0]  cos_out,
  output logic signed [ddo_pkg::CW-1:0]  sin_out
);
  import ddo_pkg::*;

  logic                 busy;
  logic                 done;
  logic                 flip;
  logic [STEP_W-1:0]    step;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] z;
  logic [31:0]          quarter;
  logic [31:0]          folded;
  logic [4:0]           k;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] at;

  assign quarter = angle + 32'h4000_0000;
  assign folded  = quarter[31] ? angle + 32'h8000_0000 : angle;
  assign k       = 5'(step);
  assign dx      = y >>> k;
  assign dy      = x >>> k;
  assign at      = $signed({{(CW-32){1'b0}}, atan_entry(k)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip <= quarter[31];
      x    <= CORDIC_X0;
      y    <= '0;
      z    <= $signed({{(CW-32){folded[31]}}, folded});
      step <= '0;
    end else if (busy) begin
      if (!z[CW-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
      step <= step + 1'b1;
    end
  end

  assign cos_out   = flip ? -x : x;
  assign sin_out   = flip ? -y : y;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[hw/rtl/ddo_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_div
// Restoring divider, one quotient bit per cycle, with saturation check.
// ----------------------------------------------------------------------------
module ddo_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ddo_pkg::PROD_W-1:0]     dividend,
  input  logic [ddo_pkg::DVS_W-1:0]      divisor,
  output ddo_pkg::div_stat_t             stat,
  output logic [ddo_pkg::QUOT_W-1:0]     quot
);
  import ddo_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic              busy;
  logic              check;
  logic              done;
  logic              ovf;
  logic [CNT_W-1:0]  cnt;
  logic [REM_W-1:0]  rem;
  logic [QUOT_W-1:0] lo;
  logic [DVS_W-1:0]  dvs;
  logic [REM_W-1:0]  trial;
  logic              ge;

  assign trial = {rem[REM_W-2:0], lo[QUOT_W-1]};
  assign ge    = trial >= REM_W'(dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      check <= 1'b0;
      done  <= 1'b0;
      ovf   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        check <= 1'b1;
        ovf   <= 1'b0;
      end else if (check) begin
        check <= 1'b0;
        // quotient will not fit: saturate
        if (rem >= REM_W'(dvs)) begin
          ovf  <= 1'b1;
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= REM_W'(dividend >> QUOT_W);
      lo  <= dividend[QUOT_W-1:0];
      dvs <= divisor;
      cnt <= CNT_W'(QUOT_W);
    end else if (busy && !check) begin
      rem  <= ge ? trial - REM_W'(dvs) : trial;
      lo   <= {lo[QUOT_W-2:0], 1'b0};
      quot <= {quot[QUOT_W-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.ovf  = ovf;

endmodule

[bench/tb_differential_drive_odometry.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_differential_drive_odometry
// Self-checking bench for the wheel odometry block: directed items for the
// first sample, stalled or reversed time, wrapping and extreme counts, then
// random motion under several register settings, with random stalls on both
// channels and every result checked against an in-bench pose predictor.
// ----------------------------------------------------------------------------
module tb_differential_drive_odometry;
  import ddo_pkg::*;

  typedef struct {
    logic signed [31:0] px, py, hd, vx, vy, vh;
    logic               vv;
  } pose_t;

  localparam longint ACC_LIMIT = 64'sd140737488355327;
  localparam longint ATAN_BAM [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_index = REG_START_LEFT;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] count_left = '0, count_right = '0;
  logic [47:0] time_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] pos_x, pos_y, heading, vel_x, vel_y, vel_heading;
  logic velocity_valid;

  differential_drive_odometry dut (.*);

  always #10 clk = ~clk;

  // predictor state
  logic [31:0] start_l, start_r, mpc, iwb;
  logic [31:0] prev_l, prev_r, head_acc;
  logic [47:0] last_t;
  bit          t_seen;
  longint      pos_acc_x, pos_acc_y;

  pose_t pending_poses[$];
  int    errors = 0;
  bit    calm = 0;

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 28);
  endfunction

  always @(posedge clk) out_ready <= !idle_now();

  function automatic logic [63:0] mag64(longint v);
    logic [63:0] u;
    u = v;
    return (v < 0) ? 64'd0 - u : u;
  endfunction

  function automatic longint clamp_mag(logic [127:0] m, bit neg, int bits);
    logic [127:0] mx;
    mx = (128'd1 << (bits - 1)) - 128'd1;
    if (m > mx) return neg ? -longint'(mx[63:0]) - 1 : longint'(mx[63:0]);
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint scaled_product(longint a, longint b);
    logic [127:0] p;
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    p = p >> XD_SHIFT;
    return clamp_mag(p, (a < 0) != (b < 0), 64);
  endfunction

  function automatic longint acc_add(longint acc, longint d);
    longint r;
    if (d > 2 * ACC_LIMIT) d = 2 * ACC_LIMIT;
    if (d < -2 * ACC_LIMIT) d = -2 * ACC_LIMIT;
    r = acc + d;
    if (r > ACC_LIMIT) r = ACC_LIMIT;
    if (r < -ACC_LIMIT - 1) r = -ACC_LIMIT - 1;
    return r;
  endfunction

  task automatic sin_cos(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] t;
    bit flip;
    longint x, y, z, dx, dy;
    t = ang + 32'h4000_0000;
    flip = t[31];
    if (flip) ang = ang + 32'h8000_0000;
    x = 652032874;
    y = 0;
    z = longint'($signed(ang));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_BAM[i];
      end else begin
        x += dx; y -= dy; z += ATAN_BAM[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [31:0] rate_q16(logic [63:0] m, bit neg, logic [47:0] dt, int sh);
    logic [127:0] p;
    p = {64'd0, m} * 128'd1000000;
    p = p / {80'd0, dt};
    p = p >> sh;
    return 32'(clamp_mag(p, neg, 32));
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic advance_pose(input logic [31:0] cl, input logic [31:0] cr,
                              input logic [47:0] t, output pose_t r);
    longint dl, dr, sum, del, total, c, s, xd, yd;
    logic [127:0] p;
    logic [63:0] rad, w;
    logic [31:0] bam, half, d32;
    bit rneg;
    d32 = cl - prev_l; dl = longint'($signed(d32));
    d32 = cr - prev_r; dr = longint'($signed(d32));
    sum = dl + dr;
    del = dl - dr;
    p = {64'd0, mag64(sum)} * {96'd0, mpc};
    total = longint'(p[64:1]);
    if (sum < 0) total = -total;
    rneg = del < 0;
    w = mag64(del) * {32'd0, mpc};
    p = {64'd0, w} * {96'd0, iwb};
    rad = p[95:32];
    p = {64'd0, rad} * {96'd0, INV_PI_Q32};
    bam = p[64:33];
    half = p[65:34];
    if (rneg) begin
      bam = -bam; half = -half;
    end
    sin_cos(head_acc + half, c, s);
    xd = scaled_product(total, c);
    yd = scaled_product(total, s);
    pos_acc_x = acc_add(pos_acc_x, xd);
    pos_acc_y = acc_add(pos_acc_y, yd);
    head_acc = head_acc + bam;
    r.vv = t_seen && (t > last_t);
    if (r.vv) begin
      r.vx = rate_q16(mag64(xd), xd < 0, t - last_t, POS_SHIFT);
      r.vy = rate_q16(mag64(yd), yd < 0, t - last_t, POS_SHIFT);
      r.vh = rate_q16(rad, rneg, t - last_t, RAD_SHIFT);
    end else begin
      r.vx = 0; r.vy = 0; r.vh = 0;
    end
    r.px = clamp32(pos_acc_x >>> POS_SHIFT);
    r.py = clamp32(pos_acc_y >>> POS_SHIFT);
    r.hd = head_acc;
    prev_l = cl;
    prev_r = cr;
    last_t = t;
    t_seen = 1;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pose_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_poses.size() == 0) begin
        report_mismatch("unexpected transfer", pos_x, 32'd0);
      end else begin
        e = pending_poses.pop_front();
        if (pos_x !== e.px) report_mismatch("pos_x", pos_x, e.px);
        if (pos_y !== e.py) report_mismatch("pos_y", pos_y, e.py);
        if (heading !== e.hd) report_mismatch("heading", heading, e.hd);
        if (vel_x !== e.vx) report_mismatch("vel_x", vel_x, e.vx);
        if (vel_y !== e.vy) report_mismatch("vel_y", vel_y, e.vy);
        if (vel_heading !== e.vh) report_mismatch("vel_heading", vel_heading, e.vh);
        if (velocity_valid !== e.vv)
          report_mismatch("velocity_valid", {31'd0, velocity_valid}, {31'd0, e.vv});
      end
    end
  end

  task automatic send_sample(input logic [31:0] cl, input logic [31:0] cr,
                             input logic [47:0] t);
    pose_t r;
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    count_left <= cl;
    count_right <= cr;
    time_us <= t;
    do @(posedge clk); while (!in_ready);
    advance_pose(cl, cr, t, r);
    pending_poses.push_back(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_START_LEFT:       begin start_l = v; prev_l = v; end
      REG_START_RIGHT:      begin start_r = v; prev_r = v; end
      REG_METERS_PER_COUNT: mpc = v;
      REG_INV_WHEEL_BASE:   iwb = v;
    endcase
  endtask

  task automatic send_random();
    logic [31:0] cl, cr;
    logic [47:0] t;
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) begin
      cl = $urandom; cr = $urandom;
    end else begin
      cl = prev_l + $urandom_range(4000) - 2000;
      cr = prev_r + $urandom_range(4000) - 2000;
    end
    sel = $urandom_range(99);
    if (sel < 5) t = last_t;
    else if (sel < 9) t = last_t - $urandom_range(1000);
    else if (sel < 13) t = 48'({$urandom, $urandom});
    else t = last_t + $urandom_range(20000, 1);
    send_sample(cl, cr, t);
  endtask

  task automatic test_time_cases();
    send_sample(32'd100, 32'd90, 48'd1000);
    send_sample(32'd200, 32'd200, 48'd1000);
    send_sample(32'd300, 32'd320, 48'd900);
    send_sample(32'd400, 32'd390, 48'd1001);
    send_sample(32'd400, 32'd390, 48'd1002);
    send_sample(32'd500, 32'd480, 48'hFFFF_FFFF_FFFF);
    send_sample(32'd501, 32'd481, 48'd0);
    send_sample(32'd502, 32'd483, 48'd1);
  endtask

  task automatic test_count_extremes();
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 48'd10);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 48'd20);
    send_sample(32'h0000_0000, 32'h0000_0000, 48'd21);
    send_sample(32'hFFFF_FFFF, 32'h0000_0001, 48'd22);
    send_sample(32'h8000_0000, 32'h8000_0000, 48'd23);
    send_sample(32'h0000_0000, 32'h0000_0000, 48'd24);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'h8000_0000_0000);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'h8000_0000_0001);
    for (int i = 0; i < 6; i++) send_sample(prev_l + 32'h4000_0000, prev_r, last_t + 1);
  endtask

  task automatic test_register_settings();
    logic [31:0] mpc_set [5] = '{32'd0, 32'hFFFF_FFFF, 32'd13703900, 32'd1, 32'h8000_0000};
    logic [31:0] iwb_set [5] = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd37617035, 32'h1234_5678};
    logic [31:0] sl_set [5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'h5555_AAAA};
    logic [31:0] sr_set [5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hAAAA_5555};
    for (int k = 0; k < 5; k++) begin
      drain();
      write_reg(REG_START_LEFT, sl_set[k]);
      write_reg(REG_START_RIGHT, sr_set[k]);
      write_reg(REG_METERS_PER_COUNT, mpc_set[k]);
      write_reg(REG_INV_WHEEL_BASE, iwb_set[k]);
      send_sample(prev_l + 32'd7, prev_r - 32'd7, last_t + 48'd500);
      send_sample(prev_l + 32'h7FFF_FFFF, prev_r + 32'h8000_0000, last_t + 48'd1);
      for (int i = 0; i < 40; i++) send_random();
    end
    drain();
    write_reg(REG_METERS_PER_COUNT, 32'd13703900);
    write_reg(REG_INV_WHEEL_BASE, 32'd37617035);
  endtask

  task automatic test_random_motion();
    for (int i = 0; i < 1400; i++) begin
      calm = (i >= 300 && i < 500);
      if (i == 900) begin
        in_valid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge clk);
      end
      send_random();
    end
    calm = 0;
  endtask

  initial begin
    start_l = 0; start_r = 0; mpc = 32'd13703900; iwb = 32'd37617035;
    prev_l = 0; prev_r = 0; head_acc = 0; last_t = 0; t_seen = 0;
    pos_acc_x = 0; pos_acc_y = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_time_cases();
    test_count_extremes();
    test_register_settings();
    test_random_motion();
    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #200ms;
    $display("status: fail");
    $finish;
  end

endmodule
